[hdl/mtrd_pkg.sv]
// Modbus TCP response decoder: shared types, codes and constants.
// Used by every module of the decoder; no dependencies.
package mtrd_pkg;

   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_AW    = $clog2(RSP_DEPTH);

   localparam logic [8:0] HDR_TXN_HI    = 9'd0;
   localparam logic [8:0] HDR_TXN_LO    = 9'd1;
   localparam logic [8:0] HDR_FUNC      = 9'd7;
   localparam logic [8:0] HDR_BYTE8     = 9'd8;
   localparam logic [8:0] PAYLOAD_START = 9'd9;
   localparam logic [8:0] POS_MAX       = 9'd511;

   localparam logic [1:0] KIND_REGS = 2'd0;
   localparam logic [1:0] KIND_BITS = 2'd1;
   localparam logic [1:0] KIND_ACK  = 2'd2;

   localparam logic [1:0] REG_RESPONSE_KIND     = 2'd0;
   localparam logic [1:0] REG_BIT_QUANTITY      = 2'd1;
   localparam logic [1:0] REG_EXPECTED_FUNCTION = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_EXCEPTION = 3'd2;
   localparam logic [2:0] ST_ODD_COUNT = 3'd3;
   localparam logic [2:0] ST_MISMATCH  = 3'd4;
   localparam logic [2:0] ST_UNDERRUN  = 3'd5;

   localparam logic RES_DATA   = 1'b0;
   localparam logic RES_STATUS = 1'b1;

   typedef struct packed {
      logic [1:0]  response_kind;
      logic [10:0] bit_quantity;
      logic [7:0]  expected_function;
   } cfg_type;

   typedef struct packed {
      logic        result_kind;
      logic [15:0] data_value;
      logic [3:0]  bit_count;
      logic [2:0]  frame_status;
      logic [7:0]  exception_code;
      logic [15:0] transaction_id;
      logic [7:0]  function_code;
      logic        is_last;
   } item_type;

   typedef struct packed {
      logic [1:0] count;
      item_type   first;
      item_type   second;
   } push_type;

endpackage

[hdl/modbus_tcp_response_decoder_top.sv]
// Modbus TCP response decoder, top level.
// Depends on mtrd_pkg, mtrd_csr, mtrd_parse and mtrd_rsp_fifo.
//
// Frame bytes enter on req_ (tdata = byte, tlast = last byte of the frame).
// Results leave on rsp_: tuser 0 is a data item (register word or coil bits),
// tuser 1 the frame status item, which is always the last of a frame (tlast).
// Registers response_kind, bit_quantity and expected_function sit at byte
// addresses 0, 4 and 8 of the csr_ port; write them only while idle.
// One frame byte is taken each cycle while req_tready is high. A byte is held in
// the input register until the queue has room, then written to the result queue,
// from which its items leave on rsp_ in order. A byte yields up to two items;
// the four-entry result queue drains one item a cycle while rsp_tready is high,
// so the final byte of a frame that also completes a word takes two output slots.
// req_tready drops while a byte waits in the input register and fewer than two
// queue entries are free, so a stalled receiver backs up to the input and nothing
// is lost. Reset clears the registers, counters and queue.
module modbus_tcp_response_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] adu_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] data_value, [19:16] bit_count, [22:20] frame_status,
   // [30:23] exception_code, [46:31] transaction_id, [54:47] function_code
   output logic [55:0] rsp_tdata,
   output logic        rsp_tuser,   // [0] result_kind
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   mtrd_pkg::cfg_type  cfg;
   mtrd_pkg::push_type push;
   mtrd_pkg::item_type item;
   logic               room;

   mtrd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mtrd_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .room       (room),
      .push       (push)
   );

   mtrd_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (item)
   );

   assign rsp_tdata = {1'b0, item.function_code, item.transaction_id, item.exception_code,
                       item.frame_status, item.bit_count, item.data_value};
   assign rsp_tuser = item.result_kind;
   assign rsp_tlast = item.is_last;

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == mtrd_pkg::RES_STATUS) == rsp_tlast))
      else $error("status item and last marker disagree");

   a_status_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[19:0] == 20'd0))
      else $error("status item carries data");

   a_data_no_header: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tdata[55:20] == 36'd0))
      else $error("data item carries header fields");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[19:16] <= 4'd8))
      else $error("bit count above eight");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("result item changed while waiting");

endmodule

[hdl/mtrd_csr.sv]
// Modbus TCP response decoder: configuration registers on an APB-style port.
// Depends on mtrd_pkg.
module mtrd_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output mtrd_pkg::cfg_type    cfg
);

   mtrd_pkg::cfg_type cfg_ff;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         unique case (csr_paddr[3:2])
            mtrd_pkg::REG_RESPONSE_KIND:     cfg_ff.response_kind     <= csr_pwdata[1:0];
            mtrd_pkg::REG_BIT_QUANTITY:      cfg_ff.bit_quantity      <= csr_pwdata[10:0];
            mtrd_pkg::REG_EXPECTED_FUNCTION: cfg_ff.expected_function <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         mtrd_pkg::REG_RESPONSE_KIND:     csr_prdata = {30'd0, cfg_ff.response_kind};
         mtrd_pkg::REG_BIT_QUANTITY:      csr_prdata = {21'd0, cfg_ff.bit_quantity};
         mtrd_pkg::REG_EXPECTED_FUNCTION: csr_prdata = {24'd0, cfg_ff.expected_function};
         default:                         csr_prdata = 32'd0;
      endcase
   end

endmodule

[hdl/mtrd_parse.sv]
// Modbus TCP response decoder: input register, frame counters and result build.
// Depends on mtrd_pkg.
module mtrd_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  mtrd_pkg::cfg_type    cfg,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tlast,
   input  logic                 room,
   output mtrd_pkg::push_type   push
);

   logic        in_v_ff;
   logic [7:0]  in_byte_ff;
   logic        in_end_ff;
   logic        fire;

   logic [8:0]  pos_ff, pos_in;
   logic [7:0]  pc_ff, pc_in;
   logic [7:0]  hold_ff, hold_in;
   logic [15:0] txn_ff, txn_in;
   logic [7:0]  fc_ff, fc_in;
   logic [7:0]  exc_ff, exc_in;
   logic [10:0] be_ff, be_in;

   logic [10:0] left;
   logic [3:0]  cnt;
   logic [8:0]  mask;
   logic [11:0] qsum;
   logic [8:0]  qbytes;
   logic        is_ack, fc_exc;
   logic        data_v;
   logic [2:0]  st;
   mtrd_pkg::item_type data_item, stat_item;

   assign fire       = in_v_ff & room;
   assign req_tready = ~in_v_ff | fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_tready) begin
         in_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   always_comb begin
      pos_in    = pos_ff;
      pc_in     = pc_ff;
      hold_in   = hold_ff;
      txn_in    = txn_ff;
      fc_in     = fc_ff;
      exc_in    = exc_ff;
      be_in     = be_ff;
      data_v    = 1'b0;
      data_item = '0;
      data_item.result_kind = mtrd_pkg::RES_DATA;
      fc_exc    = fc_ff[7];

      left = cfg.bit_quantity - be_ff;
      cnt  = (left < 11'd8) ? left[3:0] : 4'd8;
      mask = (9'd1 << cnt) - 9'd1;

      priority if (pos_ff == mtrd_pkg::HDR_TXN_HI) begin
         txn_in = {in_byte_ff, 8'h00};
      end else if (pos_ff == mtrd_pkg::HDR_TXN_LO) begin
         txn_in = {txn_ff[15:8], in_byte_ff};
      end else if (pos_ff == mtrd_pkg::HDR_FUNC) begin
         fc_in = in_byte_ff;
      end else if (pos_ff == mtrd_pkg::HDR_BYTE8) begin
         exc_in = in_byte_ff;
      end else if (pos_ff >= mtrd_pkg::PAYLOAD_START && pos_ff < mtrd_pkg::POS_MAX
                   && pc_ff < exc_ff) begin
         if (!fc_exc && cfg.response_kind == mtrd_pkg::KIND_REGS) begin
            if (!pc_ff[0]) begin
               hold_in = in_byte_ff;
            end else begin
               data_v               = 1'b1;
               data_item.data_value = {hold_ff, in_byte_ff};
            end
         end else if (!fc_exc && cfg.response_kind == mtrd_pkg::KIND_BITS
                      && be_ff < cfg.bit_quantity) begin
            data_v               = 1'b1;
            data_item.data_value = {8'h00, in_byte_ff & mask[7:0]};
            data_item.bit_count  = cnt;
            be_in                = be_ff + {7'd0, cnt};
         end
         pc_in = pc_ff + 8'd1;
      end else begin
      end

      if (pos_ff != mtrd_pkg::POS_MAX) begin
         pos_in = pos_ff + 9'd1;
      end

      // frame status, from the counters as they stand after this byte
      is_ack = cfg.response_kind[1];
      qsum   = {1'b0, cfg.bit_quantity} + 12'd7;
      qbytes = qsum[11:3];
      st     = mtrd_pkg::ST_OK;
      if (is_ack) begin
         if (pos_in >= 9'd8 && fc_in[7]) begin
            st = mtrd_pkg::ST_EXCEPTION;
         end else if (((pos_in >= 9'd8) ? fc_in : 8'h00) != cfg.expected_function) begin
            st = mtrd_pkg::ST_MISMATCH;
         end
      end else if (pos_in < 9'd9) begin
         st = mtrd_pkg::ST_SHORT;
      end else if (fc_in[7]) begin
         st = mtrd_pkg::ST_EXCEPTION;
      end else if (cfg.response_kind == mtrd_pkg::KIND_REGS) begin
         if (exc_in[0]) begin
            st = mtrd_pkg::ST_ODD_COUNT;
         end else if (pc_in < exc_in) begin
            st = mtrd_pkg::ST_SHORT;
         end
      end else begin
         if (pc_in < exc_in) begin
            st = mtrd_pkg::ST_SHORT;
         end else if (qbytes > {1'b0, exc_in}) begin
            st = mtrd_pkg::ST_UNDERRUN;
         end
      end

      stat_item                = '0;
      stat_item.result_kind    = mtrd_pkg::RES_STATUS;
      stat_item.frame_status   = st;
      stat_item.exception_code = (pos_in >= 9'd9) ? exc_in : 8'h00;
      stat_item.transaction_id = (pos_in >= 9'd2) ? txn_in : 16'h0000;
      stat_item.function_code  = (pos_in >= 9'd8) ? fc_in : 8'h00;
      stat_item.is_last        = 1'b1;

      push = '0;
      if (fire) begin
         if (data_v) begin
            push.first  = data_item;
            push.second = stat_item;
            push.count  = in_end_ff ? 2'd2 : 2'd1;
         end else begin
            push.first  = stat_item;
            push.count  = in_end_ff ? 2'd1 : 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         pc_ff   <= '0;
         hold_ff <= '0;
         txn_ff  <= '0;
         fc_ff   <= '0;
         exc_ff  <= '0;
         be_ff   <= '0;
      end else if (fire) begin
         txn_ff <= txn_in;
         fc_ff  <= fc_in;
         exc_ff <= exc_in;
         if (in_end_ff) begin
            pos_ff  <= '0;
            pc_ff   <= '0;
            hold_ff <= '0;
            be_ff   <= '0;
         end else begin
            pos_ff  <= pos_in;
            pc_ff   <= pc_in;
            hold_ff <= hold_in;
            be_ff   <= be_in;
         end
      end
   end

endmodule

[hdl/mtrd_rsp_fifo.sv]
// Modbus TCP response decoder: result queue, up to two writes and one read a cycle.
// Depends on mtrd_pkg.
module mtrd_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  mtrd_pkg::push_type   push,
   output logic                 room,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output mtrd_pkg::item_type   rsp_item
);

   localparam int unsigned AW = mtrd_pkg::RSP_AW;

   mtrd_pkg::item_type mem [mtrd_pkg::RSP_DEPTH];
   logic [AW-1:0]      wp_ff, rp_ff;
   logic [AW:0]        cnt_ff;
   logic               pop;

   assign pop        = rsp_tvalid & rsp_tready;
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_item   = mem[rp_ff];
   assign room       = (cnt_ff <= (AW+1)'(mtrd_pkg::RSP_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wp_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wp_ff + AW'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_ff + AW'(push.count);
         rp_ff  <= rp_ff + AW'(pop);
         cnt_ff <= cnt_ff + (AW+1)'(push.count) - (AW+1)'(pop);
      end
   end

endmodule
